>>> rtl/svm_pkg.sv
`default_nettype none

package svm_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int VOLT_W    = 10;
	localparam int PERSIST_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam int TENTH_DIV = 100;
	localparam logic [VOLT_W:0] LOW_MARGIN = 11'd2;
	localparam logic [VOLT_W:0] CUT_MARGIN = 11'd10;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CUT_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERSIST_COUNT = 2'd2;

	localparam logic [VOLT_W-1:0]    LOW_THRESHOLD_RST = 10'd0;
	localparam logic [VOLT_W-1:0]    CUT_THRESHOLD_RST = 10'd50;
	localparam logic [PERSIST_W-1:0] PERSIST_COUNT_RST = 8'd150;

	typedef struct packed {
		logic [PERSIST_W-1:0] hits;
		logic [PERSIST_W-1:0] clears;
	} persist_t;

	typedef struct packed {
		persist_t cnt;
		logic     fire;
		logic     lift;
	} det_t;

endpackage

`default_nettype wire

>>> rtl/supply_voltage_monitor.sv
`default_nettype none

// While the ring fills, a result is valid in the cycle after the item is taken.
// Once full, the result follows from these steps in order:
// one ring read per cycle, a trim step, a reciprocal multiply, a detector step.
// One item at a time; the next is taken the cycle after the result leaves.
// Reset: flags, counters, fill count and pointer clear; registers take their defaults.
// The sample ring is not cleared; it is always written before it is read.
module supply_voltage_monitor #(
	parameter int WINDOW_LEN = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [svm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [svm_pkg::VOLT_W-1:0]    cfg_data,

	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic [svm_pkg::SAMPLE_W-1:0]  adc_sample,

	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic [svm_pkg::VOLT_W-1:0]    voltage_tenths,
	output      logic                          window_full,
	output      logic                          low_alarm,
	output      logic                          cut_alarm
);

	localparam int PTR_W   = $clog2(WINDOW_LEN);
	localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W   = svm_pkg::SAMPLE_W + $clog2(WINDOW_LEN);
	localparam int DIVISOR = svm_pkg::TENTH_DIV * (WINDOW_LEN - 2);
	localparam int VW      = svm_pkg::VOLT_W;
	localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [63:0] RECIP =
		((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_TRIM,
		ST_DIV,
		ST_DET,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [svm_pkg::SAMPLE_W-1:0]  ring_q [WINDOW_LEN];
	logic [svm_pkg::SAMPLE_W-1:0]  rd_data_q;
	logic [PTR_W-1:0]              wp_q;
	logic [FILL_W-1:0]             fill_q;
	logic [FILL_W-1:0]             cnt_q;
	logic [SUM_W-1:0]              sum_q;
	logic [svm_pkg::SAMPLE_W-1:0]  min_q;
	logic [svm_pkg::SAMPLE_W-1:0]  max_q;
	logic [VW-1:0]                 quo_q;

	logic [VW-1:0]                 low_thr_q;
	logic [VW-1:0]                 cut_thr_q;
	logic [svm_pkg::PERSIST_W-1:0] persist_q;
	svm_pkg::persist_t             low_cnt_q;
	svm_pkg::persist_t             cut_cnt_q;
	logic                          low_flag_q;
	logic                          cut_flag_q;

	logic                          in_acc;
	logic                          filling;
	logic [PROD_W-1:0]             prod;
	logic                          low_hit, low_miss, cut_hit, cut_miss;
	svm_pkg::det_t                 low_det, cut_det;
	logic                          low_next, cut_next;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign filling   = (fill_q < FILL_W'(WINDOW_LEN));

	// divide by the constant through its rounded-up reciprocal, exact for SUM_W bits
	assign prod = PROD_W'(sum_q) * PROD_W'(RECIP[RECIP_W-1:0]);

	assign low_hit  = (quo_q < low_thr_q) && (quo_q > cut_thr_q);
	assign low_miss = ({1'b0, quo_q} > ({1'b0, low_thr_q} + svm_pkg::LOW_MARGIN));
	assign cut_hit  = (quo_q < cut_thr_q);
	assign cut_miss = ({1'b0, quo_q} > ({1'b0, cut_thr_q} + svm_pkg::CUT_MARGIN));

	svm_persist u_low_persist (
		.hit     (low_hit),
		.miss    (low_miss),
		.cnt_now (low_cnt_q),
		.limit   (persist_q),
		.result  (low_det)
	);

	svm_persist u_cut_persist (
		.hit     (cut_hit),
		.miss    (cut_miss),
		.cnt_now (cut_cnt_q),
		.limit   (persist_q),
		.result  (cut_det)
	);

	// undervoltage first, then power cut
	always_comb begin
		low_next = low_flag_q;
		cut_next = cut_flag_q;
		if (low_det.fire) begin
			low_next = 1'b1;
			cut_next = 1'b0;
		end else if (low_det.lift) begin
			low_next = 1'b0;
		end
		if (cut_det.fire) begin
			cut_next = 1'b1;
			low_next = 1'b0;
		end else if (cut_det.lift) begin
			cut_next = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			ring_q[wp_q] <= adc_sample;
		rd_data_q <= ring_q[cnt_q[PTR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sum_q <= '0;
				min_q <= '1;
				max_q <= '0;
			end
			ST_SUM: begin
				if (cnt_q != '0) begin
					sum_q <= sum_q + SUM_W'(rd_data_q);
					if (rd_data_q < min_q)
						min_q <= rd_data_q;
					if (rd_data_q > max_q)
						max_q <= rd_data_q;
				end
			end
			ST_TRIM: begin
				sum_q <= sum_q - SUM_W'(min_q) - SUM_W'(max_q);
				quo_q <= '0;
			end
			ST_DIV: begin
				quo_q <= prod[SHIFT +: VW];
			end
			ST_DET, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			wp_q           <= '0;
			fill_q         <= '0;
			cnt_q          <= '0;
			low_thr_q      <= svm_pkg::LOW_THRESHOLD_RST;
			cut_thr_q      <= svm_pkg::CUT_THRESHOLD_RST;
			persist_q      <= svm_pkg::PERSIST_COUNT_RST;
			low_cnt_q      <= '0;
			cut_cnt_q      <= '0;
			low_flag_q     <= 1'b0;
			cut_flag_q     <= 1'b0;
			out_valid      <= 1'b0;
			voltage_tenths <= '0;
			window_full    <= 1'b0;
			low_alarm      <= 1'b0;
			cut_alarm      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == svm_pkg::REG_LOW_THRESHOLD)
					low_thr_q <= cfg_data;
				else if (cfg_index == svm_pkg::REG_CUT_THRESHOLD)
					cut_thr_q <= cfg_data;
				else if (cfg_index == svm_pkg::REG_PERSIST_COUNT)
					persist_q <= cfg_data[svm_pkg::PERSIST_W-1:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						wp_q  <= (wp_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : wp_q + 1'b1;
						cnt_q <= '0;
						if (filling) begin
							fill_q         <= fill_q + 1'b1;
							out_valid      <= 1'b1;
							voltage_tenths <= '0;
							window_full    <= 1'b0;
							low_alarm      <= low_flag_q;
							cut_alarm      <= cut_flag_q;
							state_q        <= ST_OUT;
						end else begin
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == FILL_W'(WINDOW_LEN))
						state_q <= ST_TRIM;
				end
				ST_TRIM: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_DET;
				end
				ST_DET: begin
					low_cnt_q      <= low_det.cnt;
					cut_cnt_q      <= cut_det.cnt;
					low_flag_q     <= low_next;
					cut_flag_q     <= cut_next;
					out_valid      <= 1'b1;
					voltage_tenths <= quo_q;
					window_full    <= 1'b1;
					low_alarm      <= low_next;
					cut_alarm      <= cut_next;
					state_q        <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result waits");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(low_flag_q && cut_flag_q))
		else $error("both alarms set");

	a_fill_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && filling) |=> (out_valid && !window_full && voltage_tenths == '0))
		else $error("filling item gave a wrong result");

	a_div_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |=> (state_q == ST_DET))
		else $error("division took more than one cycle");

endmodule

`default_nettype wire

>>> rtl/svm_persist.sv
`default_nettype none

// persistence counter pair for one hysteresis detector
module svm_persist (
	input  wire logic                          hit,
	input  wire logic                          miss,
	input  wire svm_pkg::persist_t             cnt_now,
	input  wire logic [svm_pkg::PERSIST_W-1:0] limit,
	output svm_pkg::det_t                      result
);

	svm_pkg::persist_t cnt_new;

	always_comb begin
		cnt_new = cnt_now;
		if (hit) begin
			if (cnt_now.hits < limit)
				cnt_new.hits = cnt_now.hits + 8'd1;
			cnt_new.clears = '0;
		end else if (miss) begin
			cnt_new.hits = '0;
			if (cnt_now.clears < limit)
				cnt_new.clears = cnt_now.clears + 8'd1;
		end
		result.cnt  = cnt_new;
		result.fire = (cnt_new.hits >= limit);
		result.lift = (cnt_new.clears >= limit);
	end

endmodule

`default_nettype wire

>>> verif/supply_voltage_monitor_tb.sv
`timescale 1ns / 100ps

module supply_voltage_monitor_tb;

	localparam int WINDOW       = 6;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 58;
	localparam int HOLD_CYCLES  = 80;
	localparam int SETTLE_WAIT  = 30;
	localparam int SHOW_LIMIT   = 10;
	localparam logic [svm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [svm_pkg::VOLT_W-1:0] volts;
		logic                       full;
		logic                       low;
		logic                       cut;
	} reading_t;

	typedef struct packed {
		row_kind_t                     kind;
		logic [svm_pkg::CFG_IDX_W-1:0] idx;
		logic [svm_pkg::VOLT_W-1:0]    data;
		logic [svm_pkg::SAMPLE_W-1:0]  sample;
		logic                          typed;
		reading_t                      want;
	} row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [svm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [svm_pkg::VOLT_W-1:0]    cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [svm_pkg::SAMPLE_W-1:0]  adc_sample = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [svm_pkg::VOLT_W-1:0]    voltage_tenths;
	logic                          window_full;
	logic                          low_alarm;
	logic                          cut_alarm;

	// monitor state mirrored in the bench
	logic [svm_pkg::VOLT_W-1:0]    low_thr = svm_pkg::LOW_THRESHOLD_RST;
	logic [svm_pkg::VOLT_W-1:0]    cut_thr = svm_pkg::CUT_THRESHOLD_RST;
	logic [svm_pkg::PERSIST_W-1:0] persist = svm_pkg::PERSIST_COUNT_RST;
	logic [svm_pkg::SAMPLE_W-1:0]  ring [WINDOW];
	int                            ring_wr = 0;
	int                            ring_fill = 0;
	logic [svm_pkg::PERSIST_W-1:0] low_hits = '0;
	logic [svm_pkg::PERSIST_W-1:0] low_clears = '0;
	logic [svm_pkg::PERSIST_W-1:0] cut_hits = '0;
	logic [svm_pkg::PERSIST_W-1:0] cut_clears = '0;
	logic                          low_flag = 1'b0;
	logic                          cut_flag = 1'b0;

	reading_t pending_readings [$];

	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int samples_sent = 0;
	int cfg_writes = 0;
	int results_seen = 0;
	int averaged_seen = 0;
	int low_seen = 0;
	int cut_seen = 0;
	int fail_count = 0;

	supply_voltage_monitor #(
		.WINDOW_LEN(WINDOW)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.adc_sample     (adc_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.voltage_tenths (voltage_tenths),
		.window_full    (window_full),
		.low_alarm      (low_alarm),
		.cut_alarm      (cut_alarm)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [svm_pkg::PERSIST_W-1:0] bump(
			input logic [svm_pkg::PERSIST_W-1:0] c);
		return (c < persist) ? c + 8'd1 : c;
	endfunction

	function automatic reading_t predict_reading(input logic [svm_pkg::SAMPLE_W-1:0] s);
		reading_t    r;
		int unsigned lo;
		int unsigned hi;
		int unsigned total;
		int unsigned v;
		ring[ring_wr] = s;
		ring_wr = (ring_wr == WINDOW - 1) ? 0 : ring_wr + 1;
		if (ring_fill < WINDOW) begin
			ring_fill++;
			r = '{volts: '0, full: 1'b0, low: low_flag, cut: cut_flag};
			return r;
		end
		lo = 32'hFFFF;
		hi = 0;
		total = 0;
		for (int i = 0; i < WINDOW; i++) begin
			if (ring[i] < lo) lo = ring[i];
			if (ring[i] > hi) hi = ring[i];
			total += ring[i];
		end
		v = ((total - lo - hi) / (WINDOW - 2)) / svm_pkg::TENTH_DIV;

		if (v < low_thr && v > cut_thr) begin
			low_hits = bump(low_hits);
			low_clears = '0;
		end else if (v > low_thr + svm_pkg::LOW_MARGIN) begin
			low_hits = '0;
			low_clears = bump(low_clears);
		end
		if (low_hits >= persist) begin
			low_flag = 1'b1;
			cut_flag = 1'b0;
		end else if (low_clears >= persist) begin
			low_flag = 1'b0;
		end

		if (v < cut_thr) begin
			cut_hits = bump(cut_hits);
			cut_clears = '0;
		end else if (v > cut_thr + svm_pkg::CUT_MARGIN) begin
			cut_hits = '0;
			cut_clears = bump(cut_clears);
		end
		if (cut_hits >= persist) begin
			cut_flag = 1'b1;
			low_flag = 1'b0;
		end else if (cut_clears >= persist) begin
			cut_flag = 1'b0;
		end

		r = '{volts: svm_pkg::VOLT_W'(v), full: 1'b1, low: low_flag, cut: cut_flag};
		return r;
	endfunction

	function automatic logic [svm_pkg::SAMPLE_W-1:0] level_sample(input int tenths);
		int mv;
		if ($urandom_range(0, 7) == 0) return svm_pkg::SAMPLE_W'($urandom);
		mv = tenths * 100 + int'($urandom_range(0, 99));
		return (mv > 65535) ? 16'hFFFF : svm_pkg::SAMPLE_W'(mv);
	endfunction

	function automatic row_t item_row(input logic [svm_pkg::SAMPLE_W-1:0] s);
		return '{kind: ROW_ITEM, idx: '0, data: '0, sample: s, typed: 1'b0, want: '0};
	endfunction

	function automatic row_t checked_row(input logic [svm_pkg::SAMPLE_W-1:0] s,
			input reading_t want);
		return '{kind: ROW_ITEM, idx: '0, data: '0, sample: s, typed: 1'b1, want: want};
	endfunction

	function automatic row_t cfg_row(input logic [svm_pkg::CFG_IDX_W-1:0] idx,
			input logic [svm_pkg::VOLT_W-1:0] data);
		return '{kind: ROW_CFG, idx: idx, data: data, sample: '0, typed: 1'b0, want: '0};
	endfunction

	function automatic void note_mismatch(input string what, input reading_t want,
			input reading_t got);
		fail_count++;
		if (fail_count <= SHOW_LIMIT) begin
			$display("%t: %s: expected volts=%0d full=%0b low=%0b cut=%0b, ",
				$realtime, what, want.volts, want.full, want.low, want.cut,
				"got volts=%0d full=%0b low=%0b cut=%0b",
				got.volts, got.full, got.low, got.cut);
		end
	endfunction

	// register writes only once the monitor has drained
	task automatic write_reg(input logic [svm_pkg::CFG_IDX_W-1:0] idx,
			input logic [svm_pkg::VOLT_W-1:0] data);
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		unique case (idx)
			svm_pkg::REG_LOW_THRESHOLD: low_thr = data;
			svm_pkg::REG_CUT_THRESHOLD: cut_thr = data;
			svm_pkg::REG_PERSIST_COUNT: persist = data[svm_pkg::PERSIST_W-1:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic send_sample(input logic [svm_pkg::SAMPLE_W-1:0] s, input logic typed,
			input reading_t want);
		int       gap;
		reading_t pred;
		gap = tx_steady ? 0 : $urandom_range(0, 3);
		cfg_valid <= 1'b0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = predict_reading(s);
		pending_readings.push_back(typed ? want : pred);
		samples_sent++;
	endtask

	initial begin : result_check
		reading_t got;
		reading_t want;
		int       gap;
		@(posedge arst_n);
		forever begin
			if (results_seen == 150 || results_seen == 420) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (results_seen % 64 == 0) rx_steady = ($urandom_range(0, 2) == 0);
			gap = rx_steady ? 0 : $urandom_range(0, 3);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got = '{volts: voltage_tenths, full: window_full, low: low_alarm, cut: cut_alarm};
			results_seen++;
			if (got.full === 1'b1) averaged_seen++;
			if (got.low === 1'b1) low_seen++;
			if (got.cut === 1'b1) cut_seen++;
			if (pending_readings.size() == 0) begin
				note_mismatch("unexpected reading", '0, got);
			end else begin
				want = pending_readings.pop_front();
				if (got.volts !== want.volts || got.full !== want.full ||
						got.low !== want.low || got.cut !== want.cut)
					note_mismatch("reading mismatch", want, got);
			end
		end
	end

	initial begin : stimulus
		row_t rows [$];
		int   lt;
		int   ct;
		int   pc;
		int   sent;
		int   run_len;
		int   target;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill from reset: extremes and alternating bits
		rows.push_back(checked_row(16'h0000, '0));
		rows.push_back(checked_row(16'hFFFF, '0));
		rows.push_back(checked_row(16'hAAAA, '0));
		rows.push_back(checked_row(16'h5555, '0));
		rows.push_back(checked_row(16'h0001, '0));
		rows.push_back(checked_row(16'h8000, '0));
		// zero persistence: cut alarm forced every averaged tick
		rows.push_back(cfg_row(svm_pkg::REG_PERSIST_COUNT, 10'd0));
		repeat (5) rows.push_back(item_row(16'hFFFF));
		rows.push_back(checked_row(16'hFFFF, '{volts: 10'd655, full: 1'b1, low: 1'b0,
			cut: 1'b1}));
		// threshold extremes, upper data bits on persistence, unknown index
		rows.push_back(cfg_row(svm_pkg::REG_LOW_THRESHOLD, 10'd1023));
		rows.push_back(cfg_row(svm_pkg::REG_CUT_THRESHOLD, 10'd0));
		rows.push_back(cfg_row(svm_pkg::REG_PERSIST_COUNT, 10'h3FF));
		rows.push_back(cfg_row(REG_UNUSED, 10'h155));
		repeat (2) rows.push_back(item_row(16'd20000));
		rows.push_back(cfg_row(svm_pkg::REG_PERSIST_COUNT, 10'd4));
		repeat (5) rows.push_back(item_row(16'd20000));
		// persistence lowered below the running counts
		rows.push_back(cfg_row(svm_pkg::REG_PERSIST_COUNT, 10'd2));
		repeat (2) rows.push_back(item_row(16'd20000));
		rows.push_back(cfg_row(svm_pkg::REG_LOW_THRESHOLD, 10'd0));
		rows.push_back(cfg_row(svm_pkg::REG_CUT_THRESHOLD, 10'd1023));
		repeat (3) rows.push_back(item_row(16'd0));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) write_reg(rows[i].idx, rows[i].data);
			else send_sample(rows[i].sample, rows[i].typed, rows[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin lt = 1023; ct = 0; pc = 1; end
				1: begin lt = 0; ct = 1023; pc = 255; end
				2: begin
					ct = $urandom_range(0, 300);
					lt = ct + int'($urandom_range(5, 200));
					pc = 0;
				end
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						lt = $urandom_range(0, 1023);
						ct = $urandom_range(0, 1023);
					end else begin
						ct = $urandom_range(0, 300);
						lt = ct + int'($urandom_range(5, 200));
					end
					pc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
						: $urandom_range(1, 6);
				end
			endcase
			write_reg(svm_pkg::REG_LOW_THRESHOLD, svm_pkg::VOLT_W'(lt));
			write_reg(svm_pkg::REG_CUT_THRESHOLD, svm_pkg::VOLT_W'(ct));
			write_reg(svm_pkg::REG_PERSIST_COUNT, {2'($urandom), 8'(pc)});
			if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, svm_pkg::VOLT_W'($urandom));
			tx_steady = ($urandom_range(0, 3) == 0);

			// runs held near one level so the persistence counters get somewhere
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				run_len = $urandom_range(2, 12);
				case ($urandom_range(0, 5))
					0: target = (ct > 0) ? $urandom_range(0, ct - 1) : 0;
					1: target = (lt > ct + 1) ? $urandom_range(ct + 1, lt - 1)
						: $urandom_range(0, 654);
					2: target = lt - 3 + int'($urandom_range(0, 7));
					3: target = ct - 2 + int'($urandom_range(0, 14));
					4: target = lt + 3 + int'($urandom_range(0, 40));
					default: target = $urandom_range(0, 654);
				endcase
				if (target < 0) target = 0;
				if (target > 654) target = 654;
				repeat (run_len) begin
					send_sample(level_sample(target), 1'b0, '0);
					sent++;
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
		if (pending_readings.size() != 0) begin
			fail_count += pending_readings.size();
			$display("%0d readings never arrived", pending_readings.size());
		end
		$display("Sent %0d samples with %0d register writes; %0d readings, %0d averaged.",
			samples_sent, cfg_writes, results_seen, averaged_seen);
		$display("Undervoltage alarm up on %0d readings, power cut alarm on %0d.",
			low_seen, cut_seen);
		if (fail_count == 0) begin
			$display("** supply_voltage_monitor: PASSED **");
		end else begin
			$display("%0d failures", fail_count);
			$display("** supply_voltage_monitor: FAILED **");
		end
		$finish;
	end

	initial begin : watchdog
		#(5_000_000);
		$display("timeout: %0d readings still pending", pending_readings.size());
		$display("** supply_voltage_monitor: FAILED **");
		$finish;
	end

endmodule
